### rtl/core/cd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cd_pkg;

   localparam int IN_W   = 16;
   localparam int OUT_W  = 32;
   localparam int FRAC   = 15;
   localparam int MAG_W  = IN_W + 1;
   localparam int NUM_W  = IN_W + 2;
   localparam int QB     = MAG_W + FRAC;
   localparam int RM_W   = FRAC + 1;
   localparam int PROD_W = RM_W + IN_W;
   localparam int SAT_W  = (QB > OUT_W) ? QB : OUT_W;

   localparam logic [SAT_W-1:0] LIM_NEG = SAT_W'(64'd1 << (OUT_W - 1));
   localparam logic [SAT_W-1:0] LIM_POS = SAT_W'((64'd1 << (OUT_W - 1)) - 64'd1);

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_ZERO = 2'd1;
   localparam logic [1:0] ST_SAT  = 2'd2;

   typedef struct packed {
      logic signed [IN_W-1:0] dividend_real;
      logic signed [IN_W-1:0] dividend_imag;
      logic signed [IN_W-1:0] divisor_real;
      logic signed [IN_W-1:0] divisor_imag;
   } cd_req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] quotient_real;
      logic signed [OUT_W-1:0] quotient_imag;
      logic [1:0]              status;
   } cd_rsp_type;

   typedef struct packed {
      logic [MAG_W-1:0] rem;
      logic [MAG_W-1:0] div;
      logic [QB-1:0]    num;
      logic [QB-1:0]    quo;
   } cd_lane_type;

   function automatic logic [IN_W-1:0] cd_abs_in(input logic [IN_W-1:0] x);
      cd_abs_in = x[IN_W-1] ? (~x + 1'b1) : x;
   endfunction

   function automatic logic [MAG_W-1:0] cd_abs_num(input logic [NUM_W-1:0] x);
      logic [NUM_W-1:0] m;
      m = x[NUM_W-1] ? (~x + 1'b1) : x;
      cd_abs_num = m[MAG_W-1:0];
   endfunction

endpackage
`default_nettype wire

### rtl/core/cd_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module cd_div_cell (
   input  wire                  clock,
   input  cd_pkg::cd_lane_type  lane_up,
   output cd_pkg::cd_lane_type  lane_ff
);
   import cd_pkg::*;

   logic [MAG_W:0] trial;
   logic [MAG_W:0] diff;
   cd_lane_type    lane_in;

   always_comb begin
      trial   = {lane_up.rem, lane_up.num[QB-1]};
      diff    = trial - {1'b0, lane_up.div};
      lane_in = lane_up;
      lane_in.num = {lane_up.num[QB-2:0], 1'b0};
      if (trial >= {1'b0, lane_up.div}) begin
         lane_in.rem = diff[MAG_W-1:0];
         lane_in.quo = {lane_up.quo[QB-2:0], 1'b1};
      end else begin
         lane_in.rem = trial[MAG_W-1:0];
         lane_in.quo = {lane_up.quo[QB-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      lane_ff <= lane_in;
   end

endmodule
`default_nettype wire

### rtl/core/cd_div_chain.sv
`timescale 1ns / 1ps
`default_nettype none
module cd_div_chain (
   input  wire                  clock,
   input  cd_pkg::cd_lane_type  lane_up,
   output cd_pkg::cd_lane_type  lane_dn
);
   import cd_pkg::*;

   cd_lane_type lanes [QB+1];

   assign lanes[0] = lane_up;

   for (genvar i = 0; i < QB; i++) begin : g_cell
      cd_div_cell u_cell (
         .clock   (clock),
         .lane_up (lanes[i]),
         .lane_ff (lanes[i+1])
      );
   end

   assign lane_dn = lanes[QB];

endmodule
`default_nettype wire

### rtl/core/complex_divide.sv
// Channel   Ports                         Direction  Handshake
// request   start, busy, req_data         in         taken when start && !busy
// result    rsp_valid, rsp_data           out        one-cycle strobe, no backpressure
//
// One request per clock; busy stays low. Requests pass the input register, a
// chain of QB restoring-divide cells forming the Smith ratio, the product and
// sum registers, two side-by-side QB-cell chains forming both quotient parts.
// Synchronous reset clears only the valid flags; payload flows unreset.
// The receiver cannot stall: rsp_valid lasts exactly one cycle per result.
`timescale 1ns / 1ps
`default_nettype none
module complex_divide (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   output logic                busy,
   input  cd_pkg::cd_req_type  req_data,
   output logic                rsp_valid,
   output cd_pkg::cd_rsp_type  rsp_data
);
   import cd_pkg::*;

   typedef struct packed {
      logic signed [IN_W-1:0] ar;
      logic signed [IN_W-1:0] ai;
      logic signed [IN_W-1:0] lg;
      logic signed [IN_W-1:0] sm;
      logic                   dom;
      logic                   r_neg;
      logic                   zero;
   } cd_s1_type;

   typedef struct packed {
      logic neg_re;
      logic neg_im;
      logic zero;
   } cd_s2_type;

   function automatic logic [NUM_W-1:0] sx(input logic [IN_W-1:0] x);
      sx = {{(NUM_W-IN_W){x[IN_W-1]}}, x};
   endfunction

   function automatic logic [NUM_W-1:0] sprod(input logic [PROD_W-1:0] p,
                                              input logic neg);
      logic [NUM_W-1:0] m;
      m = {1'b0, p[PROD_W-1:FRAC]};
      sprod = neg ? (~m + 1'b1) : m;
   endfunction

   // input stage
   logic        v0_ff;
   cd_req_type  in_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start && !busy;
      end
      in_ff <= req_data;
   end

   assign busy = 1'b0;

   logic [IN_W-1:0] mag_r, mag_i, lg_mag, sm_mag;
   cd_s1_type       s1_in;
   cd_lane_type     lane1_up, lane1_dn;

   always_comb begin
      mag_r        = cd_abs_in(in_ff.divisor_real);
      mag_i        = cd_abs_in(in_ff.divisor_imag);
      s1_in.dom    = mag_r >= mag_i;
      s1_in.ar     = in_ff.dividend_real;
      s1_in.ai     = in_ff.dividend_imag;
      s1_in.lg     = s1_in.dom ? in_ff.divisor_real : in_ff.divisor_imag;
      s1_in.sm     = s1_in.dom ? in_ff.divisor_imag : in_ff.divisor_real;
      s1_in.r_neg  = in_ff.divisor_real[IN_W-1] ^ in_ff.divisor_imag[IN_W-1];
      s1_in.zero   = (in_ff.divisor_real == '0) && (in_ff.divisor_imag == '0);
      lg_mag       = s1_in.dom ? mag_r : mag_i;
      sm_mag       = s1_in.dom ? mag_i : mag_r;
      lane1_up.rem = '0;
      lane1_up.div = {1'b0, lg_mag};
      lane1_up.num = {1'b0, sm_mag, {FRAC{1'b0}}};
      lane1_up.quo = '0;
   end

   cd_div_chain u_ratio (
      .clock   (clock),
      .lane_up (lane1_up),
      .lane_dn (lane1_dn)
   );

   logic [QB-1:0] v1_ff;
   cd_s1_type     s1_ff [QB];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= '0;
      end else begin
         v1_ff <= {v1_ff[QB-2:0], v0_ff};
      end
      s1_ff[0] <= s1_in;
      for (int i = 1; i < QB; i++) begin
         s1_ff[i] <= s1_ff[i-1];
      end
   end

   // products of the ratio
   logic              vm1_ff;
   cd_s1_type         m1_ff;
   logic [PROD_W-1:0] p_sm_ff, p_ar_ff, p_ai_ff;
   logic [RM_W-1:0]   rm;

   assign rm = lane1_dn.quo[RM_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vm1_ff <= 1'b0;
      end else begin
         vm1_ff <= v1_ff[QB-1];
      end
      m1_ff   <= s1_ff[QB-1];
      p_sm_ff <= PROD_W'(rm) * PROD_W'(cd_abs_in(s1_ff[QB-1].sm));
      p_ar_ff <= PROD_W'(rm) * PROD_W'(cd_abs_in(s1_ff[QB-1].ar));
      p_ai_ff <= PROD_W'(rm) * PROD_W'(cd_abs_in(s1_ff[QB-1].ai));
   end

   // denominator and numerators
   logic [NUM_W-1:0] q_sm, q_ar, q_ai, den_in, nre_in, nim_in;
   logic [NUM_W-1:0] den_ff, nre_ff, nim_ff;
   logic             vm2_ff, zero2_ff;

   always_comb begin
      q_sm   = sprod(p_sm_ff, m1_ff.r_neg ^ m1_ff.sm[IN_W-1]);
      q_ar   = sprod(p_ar_ff, m1_ff.r_neg ^ m1_ff.ar[IN_W-1]);
      q_ai   = sprod(p_ai_ff, m1_ff.r_neg ^ m1_ff.ai[IN_W-1]);
      den_in = sx(m1_ff.lg) + q_sm;
      nre_in = m1_ff.dom ? (sx(m1_ff.ar) + q_ai) : (q_ar + sx(m1_ff.ai));
      nim_in = m1_ff.dom ? (sx(m1_ff.ai) - q_ar) : (q_ai - sx(m1_ff.ar));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vm2_ff <= 1'b0;
      end else begin
         vm2_ff <= vm1_ff;
      end
      den_ff   <= den_in;
      nre_ff   <= nre_in;
      nim_ff   <= nim_in;
      zero2_ff <= m1_ff.zero || (den_in == '0);
   end

   // quotient chains
   cd_lane_type lre_up, lim_up, lre_dn, lim_dn;
   cd_s2_type   s2_in;

   always_comb begin
      lre_up.rem   = '0;
      lre_up.div   = cd_abs_num(den_ff);
      lre_up.num   = {cd_abs_num(nre_ff), {FRAC{1'b0}}};
      lre_up.quo   = '0;
      lim_up.rem   = '0;
      lim_up.div   = cd_abs_num(den_ff);
      lim_up.num   = {cd_abs_num(nim_ff), {FRAC{1'b0}}};
      lim_up.quo   = '0;
      s2_in.neg_re = nre_ff[NUM_W-1] ^ den_ff[NUM_W-1];
      s2_in.neg_im = nim_ff[NUM_W-1] ^ den_ff[NUM_W-1];
      s2_in.zero   = zero2_ff;
   end

   cd_div_chain u_quo_re (
      .clock   (clock),
      .lane_up (lre_up),
      .lane_dn (lre_dn)
   );

   cd_div_chain u_quo_im (
      .clock   (clock),
      .lane_up (lim_up),
      .lane_dn (lim_dn)
   );

   logic [QB-1:0] v2_ff;
   cd_s2_type     s2_ff [QB];

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= '0;
      end else begin
         v2_ff <= {v2_ff[QB-2:0], vm2_ff};
      end
      s2_ff[0] <= s2_in;
      for (int i = 1; i < QB; i++) begin
         s2_ff[i] <= s2_ff[i-1];
      end
   end

   // saturate and drive the result
   logic [SAT_W-1:0] mag_re, mag_im, lim_re, lim_im, val_re, val_im;
   logic             sat_re, sat_im;
   cd_rsp_type       rsp_in;

   always_comb begin
      mag_re = SAT_W'(lre_dn.quo);
      mag_im = SAT_W'(lim_dn.quo);
      lim_re = s2_ff[QB-1].neg_re ? LIM_NEG : LIM_POS;
      lim_im = s2_ff[QB-1].neg_im ? LIM_NEG : LIM_POS;
      sat_re = mag_re > lim_re;
      sat_im = mag_im > lim_im;
      if (sat_re) begin
         mag_re = lim_re;
      end
      if (sat_im) begin
         mag_im = lim_im;
      end
      val_re = s2_ff[QB-1].neg_re ? (~mag_re + 1'b1) : mag_re;
      val_im = s2_ff[QB-1].neg_im ? (~mag_im + 1'b1) : mag_im;
      if (s2_ff[QB-1].zero) begin
         rsp_in.quotient_real = '0;
         rsp_in.quotient_imag = '0;
         rsp_in.status        = ST_ZERO;
      end else begin
         rsp_in.quotient_real = val_re[OUT_W-1:0];
         rsp_in.quotient_imag = val_im[OUT_W-1:0];
         rsp_in.status        = (sat_re || sat_im) ? ST_SAT : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= v2_ff[QB-1];
      end
      rsp_data <= rsp_in;
   end

endmodule
`default_nettype wire

### tb/tb_complex_divide.sv
`timescale 1ns / 1ps
module tb_complex_divide;
   import cd_pkg::*;

   localparam int LATENCY = 2 * QB + 4;
   localparam longint CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   cd_req_type req_data = '0;
   logic rsp_valid;
   cd_rsp_type rsp_data;

   complex_divide dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always #2 clock = ~clock;

   cd_req_type pending_requests[$];
   cd_rsp_type expected_quotients[$];
   int sender_idle_pct = 0;
   bit hold_requests = 1'b0;
   int errors = 0;
   longint cycles = 0;

   function automatic longint mag64(longint v);
      return v < 0 ? -v : v;
   endfunction

   // truncated (n << FRAC) / d for nonnegative n, d
   function automatic longint frac_div(longint n, longint d);
      return (n <<< FRAC) / d;
   endfunction

   function automatic longint frac_mul(longint a, longint b);
      longint m;
      m = (mag64(a) * mag64(b)) >>> FRAC;
      return ((a < 0) != (b < 0)) ? -m : m;
   endfunction

   function automatic logic [OUT_W-1:0] sat_quot(longint num, longint den, ref bit sat);
      bit neg;
      longint m, lim;
      neg = (num < 0) != (den < 0);
      m = frac_div(mag64(num), mag64(den));
      lim = neg ? (longint'(1) <<< (OUT_W - 1)) : (longint'(1) <<< (OUT_W - 1)) - 1;
      if (m > lim) begin
         m = lim;
         sat = 1'b1;
      end
      return OUT_W'(neg ? -m : m);
   endfunction

   function automatic cd_rsp_type smith_divide(cd_req_type q);
      cd_rsp_type res;
      longint ar, ai, br, bi, r, rm, den, nre, nim;
      bit sat;
      ar = q.dividend_real;
      ai = q.dividend_imag;
      br = q.divisor_real;
      bi = q.divisor_imag;
      sat = 1'b0;
      res = '0;
      res.status = ST_ZERO;
      if (br == 0 && bi == 0) return res;
      if (mag64(br) >= mag64(bi)) begin
         rm = frac_div(mag64(bi), mag64(br));
         r = ((bi < 0) != (br < 0)) ? -rm : rm;
         den = br + frac_mul(r, bi);
         nre = ar + frac_mul(r, ai);
         nim = ai - frac_mul(r, ar);
      end else begin
         rm = frac_div(mag64(br), mag64(bi));
         r = ((bi < 0) != (br < 0)) ? -rm : rm;
         den = bi + frac_mul(r, br);
         nre = frac_mul(ar, r) + ai;
         nim = frac_mul(ai, r) - ar;
      end
      if (den == 0) return res;
      res.quotient_real = sat_quot(nre, den, sat);
      res.quotient_imag = sat_quot(nim, den, sat);
      res.status = sat ? ST_SAT : ST_OK;
      return res;
   endfunction

   function automatic logic [IN_W-1:0] pick_part();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return IN_W'($urandom_range(0, 7)) - 16'd3;
         4: return IN_W'($urandom_range(0, 255)) - 16'd128;
         default: return IN_W'($urandom);
      endcase
   endfunction

   task automatic push_request(input logic [IN_W-1:0] ar, ai, br, bi);
      cd_req_type q;
      q.dividend_real = ar;
      q.dividend_imag = ai;
      q.divisor_real = br;
      q.divisor_imag = bi;
      pending_requests.push_back(q);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         expected_quotients.push_back(smith_divide(req_data));
         void'(pending_requests.pop_front());
         if (pending_requests.size() > 0 && !hold_requests &&
             $urandom_range(0, 99) >= sender_idle_pct) begin
            req_data <= pending_requests[0];
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end else if (!start && pending_requests.size() > 0 && !hold_requests &&
                   $urandom_range(0, 99) >= sender_idle_pct) begin
         req_data <= pending_requests[0];
         start <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cd_rsp_type exp_rsp;
      cycles <= cycles + 1;
      if (!reset && rsp_valid) begin
         if (expected_quotients.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_data);
            errors = errors + 1;
         end else begin
            exp_rsp = expected_quotients.pop_front();
            if (rsp_data.quotient_real !== exp_rsp.quotient_real) begin
               $display("%0t: quotient_real expected %h actual %h", $time,
                        exp_rsp.quotient_real, rsp_data.quotient_real);
               errors = errors + 1;
            end
            if (rsp_data.quotient_imag !== exp_rsp.quotient_imag) begin
               $display("%0t: quotient_imag expected %h actual %h", $time,
                        exp_rsp.quotient_imag, rsp_data.quotient_imag);
               errors = errors + 1;
            end
            if (rsp_data.status !== exp_rsp.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        exp_rsp.status, rsp_data.status);
               errors = errors + 1;
            end
         end
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL complex_divide");
         $finish;
      end
   end

   task automatic drain();
      while (pending_requests.size() > 0 || start || expected_quotients.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      push_request(16'h4000, 16'h2000, 16'h0000, 16'h0000);
      push_request(16'h8000, 16'h8000, 16'h0000, 16'h0000);
      push_request(16'h4000, 16'h4000, 16'h4000, 16'h4000);
      push_request(16'h4000, 16'hc000, 16'hc000, 16'h4000);
      push_request(16'h7fff, 16'h7fff, 16'h0001, 16'h0000);
      push_request(16'h8000, 16'h8000, 16'h0001, 16'h0001);
      push_request(16'h8000, 16'h7fff, 16'hffff, 16'h0000);
      push_request(16'h7fff, 16'h8000, 16'h0000, 16'h0001);
      push_request(16'h7fff, 16'h0000, 16'h7fff, 16'h7fff);
      push_request(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      push_request(16'h8000, 16'h0000, 16'h8000, 16'h7fff);
      push_request(16'h1234, 16'hedcb, 16'h0100, 16'h7000);
      push_request(16'h1234, 16'hedcb, 16'h7000, 16'h0100);
      push_request(16'h0000, 16'h0000, 16'h8000, 16'h0000);
      push_request(16'h7fff, 16'h0001, 16'hfffe, 16'h0003);
      push_request(16'h0001, 16'h0001, 16'h0000, 16'h7fff);
      drain();
      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 83 : 0;
         for (int i = 0; i < 600; i++)
            push_request(pick_part(), pick_part(), pick_part(), pick_part());
         if (phase == 1) begin
            while (pending_requests.size() > 300) @(posedge clock);
            hold_requests = 1'b1;
            while (start || expected_quotients.size() > 0) @(posedge clock);
            hold_requests = 1'b0;
         end
         drain();
      end
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0)
         $display("PASS complex_divide");
      else
         $display("FAIL complex_divide");
      $finish;
   end
endmodule
